@@ rtl/core/uvs_pkg.sv @@
// uvs_pkg: shared constants and types of the UV sphere vertex generator.
// Used by uvs_cordic and uv_sphere_vertex_generator; no dependencies.
package uvs_pkg;

  localparam int unsigned MAX_LAT_BANDS  = 256;
  localparam int unsigned MAX_LONG_BANDS = 256;
  localparam int unsigned VTX_PER_CELL   = 6;

  // phase division: 32 quotient bits, two per stage
  localparam int unsigned DIV_STAGES = 16;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_LAT   = CORDIC_STEPS + 1;
  localparam int unsigned CW = 34;   // x/y, Q2.30 with headroom
  localparam int unsigned ZW = 33;   // residual angle

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // arctangent of 2^-k in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004757,
    32'd42667331,  32'd21354465,  32'd10679839,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  // bit v: edge b used for vertex v
  localparam logic [VTX_PER_CELL-1:0] CORNER_LAT  = 6'b101100;
  localparam logic [VTX_PER_CELL-1:0] CORNER_LONG = 6'b110010;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_CENTER_Z   = 3'd2,
    REG_RADIUS     = 3'd3,
    REG_LONG_BANDS = 3'd4,
    REG_LAT_BANDS  = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

endpackage

@@ rtl/core/uvs_cordic.sv @@
// uvs_cordic: pipelined rotation CORDIC, sine and cosine of a 32-bit turn phase.
// One iteration per stage, quadrant folded at the output. Depends on uvs_pkg.
module uvs_cordic (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [31:0]                     phase_i,
  output logic signed [uvs_pkg::CW-1:0]   sin_o,
  output logic signed [uvs_pkg::CW-1:0]   cos_o
);

  logic signed [uvs_pkg::CW-1:0] x_q    [uvs_pkg::CORDIC_STEPS+1];
  logic signed [uvs_pkg::CW-1:0] y_q    [uvs_pkg::CORDIC_STEPS+1];
  logic signed [uvs_pkg::ZW-1:0] z_q    [uvs_pkg::CORDIC_STEPS+1];
  logic [1:0]                    quad_q [uvs_pkg::CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= uvs_pkg::CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= $signed({3'b000, phase_i[29:0]});
      quad_q[0] <= phase_i[31:30];
    end
  end

  for (genvar k = 0; k < uvs_pkg::CORDIC_STEPS; k++) begin : g_step
    logic signed [uvs_pkg::CW-1:0] dx;
    logic signed [uvs_pkg::CW-1:0] dy;
    logic signed [uvs_pkg::ZW-1:0] at;

    assign dx = y_q[k] >>> k;
    assign dy = x_q[k] >>> k;
    assign at = $signed({1'b0, uvs_pkg::ATAN_TURNS[k]});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[k][uvs_pkg::ZW-1]) begin
          x_q[k+1] <= x_q[k] - dx;
          y_q[k+1] <= y_q[k] + dy;
          z_q[k+1] <= z_q[k] - at;
        end else begin
          x_q[k+1] <= x_q[k] + dx;
          y_q[k+1] <= y_q[k] - dy;
          z_q[k+1] <= z_q[k] + at;
        end
        quad_q[k+1] <= quad_q[k];
      end
    end
  end

  logic signed [uvs_pkg::CW-1:0] xf;
  logic signed [uvs_pkg::CW-1:0] yf;
  assign xf = x_q[uvs_pkg::CORDIC_STEPS];
  assign yf = y_q[uvs_pkg::CORDIC_STEPS];

  always_comb begin
    case (uvs_pkg::quad_e'(quad_q[uvs_pkg::CORDIC_STEPS]))
      uvs_pkg::QUAD_0: begin
        cos_o = xf;
        sin_o = yf;
      end
      uvs_pkg::QUAD_1: begin
        cos_o = -yf;
        sin_o = xf;
      end
      uvs_pkg::QUAD_2: begin
        cos_o = -xf;
        sin_o = -yf;
      end
      default: begin
        cos_o = yf;
        sin_o = -xf;
      end
    endcase
  end

endmodule

@@ rtl/core/uv_sphere_vertex_generator.sv @@
// uv_sphere_vertex_generator: top level, six triangle vertices per UV sphere cell.
// Depends on uvs_pkg and uvs_cordic.
// The first vertex of a cell passes the phase divider, CORDIC stages, product
// stages and the output register; the other five follow it. Throughput: one vertex
// per cycle while the output is not stalled, set by the single vertex issue port; an
// out-of-range cell gives one error item. Reset clears the pipeline and loads the
// registers with centre 0, radius 1.0, 32 longitude and 16 latitude bands.
module uv_sphere_vertex_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         lat_index_i,
  input  logic [7:0]         long_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [15:0]        tex_u_o,
  output logic [15:0]        tex_v_o,
  output logic               last_vertex_o,
  output logic               index_error_o
);

  typedef struct packed {
    logic        vld;
    logic        last;
    logic        err;
    logic        full_lat;
    logic        full_long;
    logic [8:0]  r_lat;
    logic [8:0]  r_long;
    logic [31:0] q_lat;
    logic [31:0] q_long;
  } div_t;

  typedef struct packed {
    logic        vld;
    logic        last;
    logic        err;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
  } side_t;

  // ---------------- registers
  logic signed [31:0] center_x_q, center_y_q, center_z_q;
  logic [30:0]        radius_q;
  logic [8:0]         long_bands_q, lat_bands_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      center_z_q   <= '0;
      radius_q     <= 31'd65536;
      long_bands_q <= 9'd32;
      lat_bands_q  <= 9'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uvs_pkg::REG_CENTER_X:   center_x_q   <= cfg_wdata_i;
        uvs_pkg::REG_CENTER_Y:   center_y_q   <= cfg_wdata_i;
        uvs_pkg::REG_CENTER_Z:   center_z_q   <= cfg_wdata_i;
        uvs_pkg::REG_RADIUS:     radius_q     <= cfg_wdata_i[30:0];
        uvs_pkg::REG_LONG_BANDS: long_bands_q <= cfg_wdata_i[8:0];
        uvs_pkg::REG_LAT_BANDS:  lat_bands_q  <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  logic [8:0] nlat, nlong;
  assign nlat  = (lat_bands_q > 9'(uvs_pkg::MAX_LAT_BANDS)) ?
                 9'(uvs_pkg::MAX_LAT_BANDS) : lat_bands_q;
  assign nlong = (long_bands_q > 9'(uvs_pkg::MAX_LONG_BANDS)) ?
                 9'(uvs_pkg::MAX_LONG_BANDS) : long_bands_q;

  // ---------------- cell holder, one vertex issued per cycle unless the output stalls
  logic       en;
  logic       out_vld_q;
  logic       cell_vld_q;
  logic [2:0] cnt_q;
  logic [7:0] li_q, gi_q;
  logic       cerr_q;
  logic       issue, issue_last, in_acc;

  assign en         = !out_vld_q || !out_stall_i;
  assign issue      = cell_vld_q && en;
  assign issue_last = cerr_q || (cnt_q == 3'(uvs_pkg::VTX_PER_CELL - 1));
  assign in_stall_o = cell_vld_q && !(en && issue_last);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_vld_q <= 1'b0;
      cnt_q      <= '0;
      cerr_q     <= 1'b0;
    end else if (in_acc) begin
      cell_vld_q <= 1'b1;
      cnt_q      <= '0;
      cerr_q     <= ({1'b0, lat_index_i} >= nlat) || ({1'b0, long_index_i} >= nlong);
    end else if (issue && issue_last) begin
      cell_vld_q <= 1'b0;
    end else if (issue) begin
      cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      li_q <= lat_index_i;
      gi_q <= long_index_i;
    end
  end

  // ---------------- phase divider, two quotient bits per stage
  function automatic logic [9:0] div_bit(input logic [8:0] r, input logic [8:0] n);
    logic [9:0] t;
    logic       ge;
    logic [8:0] rn;
    t  = {r, 1'b0};
    ge = (t >= {1'b0, n});
    rn = ge ? 9'(t - {1'b0, n}) : t[8:0];
    return {ge, rn};
  endfunction

  div_t       ds_q [uvs_pkg::DIV_STAGES+1];
  div_t       ds_d0;
  logic [8:0] e_lat, e_long;

  always_comb begin
    e_lat  = {1'b0, li_q} + 9'(uvs_pkg::CORNER_LAT[cnt_q]);
    e_long = {1'b0, gi_q} + 9'(uvs_pkg::CORNER_LONG[cnt_q]);
    ds_d0           = '0;
    ds_d0.vld       = issue;
    ds_d0.last      = issue_last;
    ds_d0.err       = cerr_q;
    ds_d0.full_lat  = (e_lat == nlat);
    ds_d0.full_long = (e_long == nlong);
    ds_d0.r_lat     = ds_d0.full_lat ? '0 : e_lat;
    ds_d0.r_long    = ds_d0.full_long ? '0 : e_long;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ds_q[0] <= '0;
    else if (en) ds_q[0] <= ds_d0;
  end

  for (genvar s = 0; s < uvs_pkg::DIV_STAGES; s++) begin : g_div
    div_t nxt;
    always_comb begin
      logic [9:0] a1, a2, b1, b2;
      nxt        = ds_q[s];
      a1         = div_bit(ds_q[s].r_lat, nlat);
      a2         = div_bit(a1[8:0], nlat);
      b1         = div_bit(ds_q[s].r_long, nlong);
      b2         = div_bit(b1[8:0], nlong);
      nxt.r_lat  = a2[8:0];
      nxt.r_long = b2[8:0];
      nxt.q_lat  = {ds_q[s].q_lat[29:0], a1[9], a2[9]};
      nxt.q_long = {ds_q[s].q_long[29:0], b1[9], b2[9]};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) ds_q[s+1] <= '0;
      else if (en) ds_q[s+1] <= nxt;
    end
  end

  // ---------------- phases and texture coordinates
  function automatic logic [15:0] tex_of(input logic [31:0] q, input logic full);
    logic [16:0] fl, c, x;
    fl = full ? 17'h10000 : {1'b0, q[31:16]};
    c  = fl + 17'(!full && (|q[15:0]));
    x  = 17'h10000 - c;
    return 16'((x + 17'd1) >> 1);
  endfunction

  div_t        df;
  logic [31:0] ph_lat, ph_long;
  side_t       sb_d;

  assign df      = ds_q[uvs_pkg::DIV_STAGES];
  assign ph_long = df.full_long ? '0 : df.q_long;
  assign ph_lat  = df.full_lat ? 32'h8000_0000 : {1'b0, df.q_lat[31:1]};

  always_comb begin
    sb_d.vld   = df.vld;
    sb_d.last  = df.last;
    sb_d.err   = df.err;
    sb_d.tex_u = tex_of(df.q_long, df.full_long);
    sb_d.tex_v = tex_of(df.q_lat, df.full_lat);
  end

  // ---------------- sine and cosine
  logic signed [uvs_pkg::CW-1:0] slat, clat, slong, clong;

  uvs_cordic u_cordic_lat (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (ph_lat),
    .sin_o   (slat),
    .cos_o   (clat)
  );

  uvs_cordic u_cordic_long (
    .clk_i   (clk_i),
    .en_i    (en),
    .phase_i (ph_long),
    .sin_o   (slong),
    .cos_o   (clong)
  );

  side_t sb_q [uvs_pkg::CORDIC_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sb_q[0] <= '0;
    else if (en) sb_q[0] <= sb_d;
  end

  for (genvar s = 1; s < uvs_pkg::CORDIC_LAT; s++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sb_q[s] <= '0;
      else if (en) sb_q[s] <= sb_q[s-1];
    end
  end

  // ---------------- normals and positions
  function automatic logic [15:0] norm_of(input logic signed [uvs_pkg::CW-1:0] n);
    logic signed [uvs_pkg::CW:0] t;
    logic signed [19:0]          v;
    logic [15:0]                 r;
    t = {n[uvs_pkg::CW-1], n} + 35'sd16384;
    v = t[34:15];
    if (v > 20'sd32767)       r = 16'h7FFF;
    else if (v < -20'sd32768) r = 16'h8000;
    else                      r = v[15:0];
    return r;
  endfunction

  function automatic logic [31:0] pos_of(input logic signed [65:0] p,
                                         input logic signed [31:0] c);
    logic signed [65:0] t;
    logic signed [36:0] s;
    logic [31:0]        r;
    t = p + (66'sd1 <<< 29);
    s = {t[65], t[65:30]} + {{5{c[31]}}, c};
    if (s > 37'sd2147483647)       r = 32'h7FFF_FFFF;
    else if (s < -37'sd2147483648) r = 32'h8000_0000;
    else                           r = s[31:0];
    return r;
  endfunction

  side_t                         m1_sb_q, m2_sb_q, m3_sb_q;
  logic signed [67:0]            px_q, pz_q;
  logic signed [uvs_pkg::CW-1:0] m1_ny_q;
  logic signed [uvs_pkg::CW-1:0] nx_q, ny_q, nz_q;
  logic signed [65:0]            rx_q, ry_q, rz_q;
  logic [15:0]                   m3_nx_q, m3_ny_q, m3_nz_q;
  logic signed [67:0]            px_r, pz_r;
  logic signed [31:0]            rad_s;

  assign px_r  = px_q + (68'sd1 <<< 29);
  assign pz_r  = pz_q + (68'sd1 <<< 29);
  assign rad_s = $signed({1'b0, radius_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_sb_q <= '0;
      m2_sb_q <= '0;
      m3_sb_q <= '0;
    end else if (en) begin
      m1_sb_q <= sb_q[uvs_pkg::CORDIC_LAT-1];
      m2_sb_q <= m1_sb_q;
      m3_sb_q <= m2_sb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q    <= slat * clong;
      pz_q    <= slat * slong;
      m1_ny_q <= clat;
      nx_q    <= px_r[63:30];
      nz_q    <= pz_r[63:30];
      ny_q    <= m1_ny_q;
      rx_q    <= nx_q * rad_s;
      ry_q    <= ny_q * rad_s;
      rz_q    <= nz_q * rad_s;
      m3_nx_q <= norm_of(nx_q);
      m3_ny_q <= norm_of(ny_q);
      m3_nz_q <= norm_of(nz_q);
    end
  end

  // ---------------- output register
  logic               out_last_q, out_err_q;
  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
  logic [15:0]        norm_x_q, norm_y_q, norm_z_q, tex_u_q, tex_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      out_last_q <= 1'b0;
      out_err_q  <= 1'b0;
    end else if (en) begin
      out_vld_q  <= m3_sb_q.vld;
      out_last_q <= m3_sb_q.last;
      out_err_q  <= m3_sb_q.err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (m3_sb_q.err) begin
        pos_x_q  <= '0;
        pos_y_q  <= '0;
        pos_z_q  <= '0;
        norm_x_q <= '0;
        norm_y_q <= '0;
        norm_z_q <= '0;
        tex_u_q  <= '0;
        tex_v_q  <= '0;
      end else begin
        pos_x_q  <= pos_of(rx_q, center_x_q);
        pos_y_q  <= pos_of(ry_q, center_y_q);
        pos_z_q  <= pos_of(rz_q, center_z_q);
        norm_x_q <= m3_nx_q;
        norm_y_q <= m3_ny_q;
        norm_z_q <= m3_nz_q;
        tex_u_q  <= m3_sb_q.tex_u;
        tex_v_q  <= m3_sb_q.tex_v;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign pos_x_o       = pos_x_q;
  assign pos_y_o       = pos_y_q;
  assign pos_z_o       = pos_z_q;
  assign norm_x_o      = norm_x_q;
  assign norm_y_o      = norm_y_q;
  assign norm_z_o      = norm_z_q;
  assign tex_u_o       = tex_u_q;
  assign tex_v_o       = tex_v_q;
  assign last_vertex_o = out_last_q;
  assign index_error_o = out_err_q;

  // ---------------- assertions
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_vld_q |-> cnt_q < 3'(uvs_pkg::VTX_PER_CELL))
    else $error("vertex counter out of range");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_err_q |-> out_last_q)
    else $error("error item not marked last");

  a_take_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cell_vld_q |-> en && issue_last)
    else $error("new cell taken before the held cell is issued");

  a_cell_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> cell_vld_q && cnt_q == '0)
    else $error("accepted cell not loaded");

endmodule
